/* rtl/core/clcd_pkg.sv */
// Package for the character LCD nibble writer: types, register indexes, init command table.
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

    // Tick counter width; waits longer than 2**TIMER_WIDTH ticks saturate there.
    localparam int unsigned TIMER_WIDTH = 16;
    localparam int unsigned CFG_WIDTH   = 16;
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned REG_IDX_W   = 3;
    // Compare width: wide enough for count + 1 and for the cap 2**TIMER_WIDTH.
    localparam int unsigned CMP_WIDTH   =
        ((TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH) + 1;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_POWER_UP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INIT_LONG  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_SHORT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SETUP      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PULSE      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAP        = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_POST       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CLEAR      = 3'd7;

    localparam logic [CFG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
        16'd20000, 16'd5000, 16'd100, 16'd1000, 16'd1, 16'd1, 16'd2000, 16'd2000
    };

    // Init nibbles and the step counter landmarks of the power-up sequence.
    localparam logic [3:0] NIB_INIT_8BIT = 4'h3;
    localparam logic [3:0] NIB_INIT_4BIT = 4'h2;
    localparam logic [3:0] STEP_FIRST_CMD = 4'd4;
    localparam logic [3:0] STEP_CLEAR_CMD = 4'd6;
    localparam logic [3:0] STEP_END       = 4'd8;
    localparam logic [3:0] STEP_LAST_NIB  = 4'd3;

    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;

    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_PWR    = 10'b00_0000_0010,
        PH_IPULSE = 10'b00_0000_0100,
        PH_IWAIT  = 10'b00_0000_1000,
        PH_SETUP  = 10'b00_0001_0000,
        PH_HI     = 10'b00_0010_0000,
        PH_GAP    = 10'b00_0100_0000,
        PH_LO     = 10'b00_1000_0000,
        PH_POST   = 10'b01_0000_0000,
        PH_CLEAR  = 10'b10_0000_0000
    } t_phase;

    // One result, packed into the output tdata from bit 0 up.
    typedef struct packed {
        logic [5:0] pad;
        logic       accepted;
        logic       init_done;
        logic       busy_res;
        logic [3:0] data_nibble;
        logic       enable_pin;
        logic       rw_pin;
        logic       rs_pin;
    } t_result;

    function automatic logic [7:0] init_cmd(input logic [1:0] sel);
        logic [7:0] cmd;
        unique case (sel)
            2'd0: cmd = CMD_FUNC_SET;
            2'd1: cmd = CMD_DISP_ON;
            2'd2: cmd = CMD_CLEAR;
            2'd3: cmd = CMD_ENTRY;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/char_lcd_nibble_writer.sv */
// Character LCD writer for a 4-bit bus: power-up init, then byte writes as two nibbles.
// Each result is registered onto m_axis, via the skid entry while m_axis stalls.
// Throughput: one request per cycle unless the skid is full; a two-entry output stage
//   (result reg + skid) keeps s_axis_tready high while one result waits on m_axis.
// Reset (i_rst_n low, synchronous): timing registers return to defaults, the sequencer
//   restarts the power-up wait, pins drive low, both output entries are emptied.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [1:0]  s_axis_tuser,   // [0] action (0 tick, 1 write), [1] is_data
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [0] rs_pin, [1] rw_pin, [2] enable_pin,
                                             // [6:3] data_nibble, [7] busy_res,
                                             // [8] init_done, [9] accepted, [15:10] zero
    // timing register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [clcd_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [clcd_pkg::CFG_WIDTH-1:0] i_cfg_data
);

    localparam int unsigned TW = clcd_pkg::TIMER_WIDTH;
    localparam int unsigned CW = clcd_pkg::CMP_WIDTH;

    // ---------------------------------------------------------------- timing registers
    logic [clcd_pkg::CFG_WIDTH-1:0] r_cfg [clcd_pkg::NUM_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(clcd_pkg::NUM_REGS); i++) begin
                r_cfg[i] <= clcd_pkg::REG_RESET[i];
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------- sequencer state
    clcd_pkg::t_phase r_phase, n_phase;
    logic [TW-1:0]    r_wait_count, n_wait_count;
    logic [7:0]       r_held_byte, n_held_byte;
    logic [3:0]       r_init_step, n_init_step;
    logic             r_rs, n_rs;
    logic             r_en, n_en;
    logic [3:0]       r_nibble, n_nibble;
    logic             r_ready_flag, n_ready_flag;
    logic             n_took;

    logic             s_accept;
    logic             req_action;
    logic             req_is_data;

    assign s_accept    = s_axis_tvalid & s_axis_tready;
    assign req_action  = s_axis_tuser[0];
    assign req_is_data = s_axis_tuser[1];

    // Length of the wait in the current phase.
    logic [clcd_pkg::CFG_WIDTH-1:0] phase_ticks;

    always_comb begin
        unique case (r_phase)
            clcd_pkg::PH_PWR:    phase_ticks = r_cfg[clcd_pkg::REG_POWER_UP];
            clcd_pkg::PH_IPULSE: phase_ticks = r_cfg[clcd_pkg::REG_PULSE];
            clcd_pkg::PH_IWAIT:  phase_ticks = (r_init_step == 4'd0)
                                               ? r_cfg[clcd_pkg::REG_INIT_LONG]
                                               : r_cfg[clcd_pkg::REG_INIT_SHORT];
            clcd_pkg::PH_SETUP:  phase_ticks = r_cfg[clcd_pkg::REG_SETUP];
            clcd_pkg::PH_HI:     phase_ticks = r_cfg[clcd_pkg::REG_PULSE];
            clcd_pkg::PH_GAP:    phase_ticks = r_cfg[clcd_pkg::REG_GAP];
            clcd_pkg::PH_LO:     phase_ticks = r_cfg[clcd_pkg::REG_PULSE];
            clcd_pkg::PH_POST:   phase_ticks = r_cfg[clcd_pkg::REG_POST];
            clcd_pkg::PH_CLEAR:  phase_ticks = r_cfg[clcd_pkg::REG_CLEAR];
            default:             phase_ticks = '0;
        endcase
    end

    // Wait ends when count + 1 reaches max(ticks, 1), capped at 2**TW.
    logic [CW-1:0] cnt_plus1, lim_raw, lim_cap, lim;
    logic          wait_done;

    assign cnt_plus1 = CW'(r_wait_count) + CW'(1);
    assign lim_raw   = (phase_ticks == '0) ? CW'(1) : CW'(phase_ticks);
    assign lim_cap   = CW'(1) << TW;
    assign lim       = (lim_raw > lim_cap) ? lim_cap : lim_raw;
    assign wait_done = (cnt_plus1 >= lim);

    logic [3:0] step_inc;
    assign step_inc = r_init_step + 4'd1;

    always_comb begin
        n_phase      = r_phase;
        n_wait_count = r_wait_count;
        n_held_byte  = r_held_byte;
        n_init_step  = r_init_step;
        n_rs         = r_rs;
        n_en         = r_en;
        n_nibble     = r_nibble;
        n_ready_flag = r_ready_flag;
        n_took       = 1'b0;

        if (req_action) begin
            // write request: only taken when idle after init
            if (r_phase == clcd_pkg::PH_IDLE && r_ready_flag) begin
                n_held_byte  = s_axis_tdata;
                n_rs         = req_is_data;
                n_en         = 1'b0;
                n_wait_count = '0;
                n_phase      = clcd_pkg::PH_SETUP;
                n_took       = 1'b1;
            end
        end else if (r_phase != clcd_pkg::PH_IDLE) begin
            if (!wait_done) begin
                n_wait_count = r_wait_count + TW'(1);
            end else begin
                n_wait_count = '0;
                unique case (r_phase)
                    clcd_pkg::PH_PWR: begin
                        n_rs        = 1'b0;
                        n_nibble    = clcd_pkg::NIB_INIT_8BIT;
                        n_en        = 1'b1;
                        n_init_step = 4'd0;
                        n_phase     = clcd_pkg::PH_IPULSE;
                    end
                    clcd_pkg::PH_IPULSE: begin
                        n_en    = 1'b0;
                        n_phase = clcd_pkg::PH_IWAIT;
                    end
                    clcd_pkg::PH_IWAIT: begin
                        if (step_inc <= clcd_pkg::STEP_LAST_NIB) begin
                            n_init_step = step_inc;
                            n_nibble    = (step_inc < clcd_pkg::STEP_LAST_NIB)
                                          ? clcd_pkg::NIB_INIT_8BIT
                                          : clcd_pkg::NIB_INIT_4BIT;
                            n_en        = 1'b1;
                            n_phase     = clcd_pkg::PH_IPULSE;
                        end else begin
                            // nibble init over: first command (function set)
                            n_init_step = clcd_pkg::STEP_FIRST_CMD;
                            n_held_byte = clcd_pkg::CMD_FUNC_SET;
                            n_rs        = 1'b0;
                            n_en        = 1'b0;
                            n_phase     = clcd_pkg::PH_SETUP;
                        end
                    end
                    clcd_pkg::PH_SETUP: begin
                        n_nibble = r_held_byte[7:4];
                        n_en     = 1'b1;
                        n_phase  = clcd_pkg::PH_HI;
                    end
                    clcd_pkg::PH_HI: begin
                        n_en    = 1'b0;
                        n_phase = clcd_pkg::PH_GAP;
                    end
                    clcd_pkg::PH_GAP: begin
                        n_nibble = r_held_byte[3:0];
                        n_en     = 1'b1;
                        n_phase  = clcd_pkg::PH_LO;
                    end
                    clcd_pkg::PH_LO: begin
                        n_en    = 1'b0;
                        n_phase = clcd_pkg::PH_POST;
                    end
                    clcd_pkg::PH_POST, clcd_pkg::PH_CLEAR: begin
                        if (r_phase == clcd_pkg::PH_POST && r_ready_flag) begin
                            n_phase = clcd_pkg::PH_IDLE;
                        end else if (r_phase == clcd_pkg::PH_POST &&
                                     r_init_step == clcd_pkg::STEP_CLEAR_CMD) begin
                            // clear display needs its extra wait
                            n_phase = clcd_pkg::PH_CLEAR;
                        end else begin
                            // next init command, or init finished
                            n_init_step = step_inc;
                            if (step_inc >= clcd_pkg::STEP_FIRST_CMD &&
                                step_inc < clcd_pkg::STEP_END) begin
                                n_held_byte = clcd_pkg::init_cmd(step_inc[1:0]);
                                n_rs        = 1'b0;
                                n_en        = 1'b0;
                                n_phase     = clcd_pkg::PH_SETUP;
                            end else begin
                                n_ready_flag = 1'b1;
                                n_en         = 1'b0;
                                n_phase      = clcd_pkg::PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_phase = clcd_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= clcd_pkg::PH_PWR;
            r_wait_count <= '0;
            r_held_byte  <= '0;
            r_init_step  <= '0;
            r_rs         <= 1'b0;
            r_en         <= 1'b0;
            r_nibble     <= '0;
            r_ready_flag <= 1'b0;
        end else if (s_accept) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_held_byte  <= n_held_byte;
            r_init_step  <= n_init_step;
            r_rs         <= n_rs;
            r_en         <= n_en;
            r_nibble     <= n_nibble;
            r_ready_flag <= n_ready_flag;
        end
    end

    // ---------------------------------------------------------------- result stage
    clcd_pkg::t_result n_result;

    always_comb begin
        n_result             = '0;
        n_result.rs_pin      = n_rs;
        n_result.rw_pin      = 1'b0;
        n_result.enable_pin  = n_en;
        n_result.data_nibble = n_nibble;
        n_result.busy_res    = (n_phase != clcd_pkg::PH_IDLE);
        n_result.init_done   = n_ready_flag;
        n_result.accepted    = n_took;
    end

    // Result register plus one skid entry; input side stalls only when both are full.
    logic              r_out_valid, r_skid_valid;
    clcd_pkg::t_result r_out, r_skid;

    assign s_axis_tready = ~r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= s_accept;
            end
        end else if (s_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (s_accept) begin
                r_out <= n_result;
            end
        end else if (s_accept) begin
            r_skid <= n_result;
        end
    end

`ifndef SYNTHESIS
    // idle is only reachable once the power-up sequence has completed
    a_idle_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == clcd_pkg::PH_IDLE) |-> r_ready_flag)
        else $error("sequencer idle before init done");

    // enable is only high in the pulse phases
    a_en_in_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en |-> (r_phase == clcd_pkg::PH_IPULSE || r_phase == clcd_pkg::PH_HI ||
                  r_phase == clcd_pkg::PH_LO))
        else $error("enable high outside a pulse phase");

    // the tick counter is cleared whenever the sequencer goes idle
    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == clcd_pkg::PH_IDLE) |-> (r_wait_count == '0))
        else $error("wait count left nonzero in idle");

    // skid entry only holds a result behind a full result register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty result register");
`endif

endmodule

`default_nettype wire
